// ===== sv/bsd_pkg.sv =====
// Package: widths, item types, register codes and state encodings of the block sum decimator.
`default_nettype none

package bsd_pkg;

  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned SAMPLE_USE = 32;
  localparam int unsigned FACTOR_W   = 9;
  localparam int unsigned POS_W      = 21;
  localparam int unsigned ACC_W      = 40;
  localparam int unsigned OUT_W      = 48;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned MAX_FACTOR = 256;
  localparam int unsigned NUM_W      = ACC_W + FRAC_BITS;
  localparam int unsigned CNT_W      = $clog2(NUM_W);
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECIM_FACTOR   = 8'd0,
    CFG_START_POSITION = 8'd1,
    CFG_END_POSITION   = 8'd2,
    CFG_AVERAGE_ENABLE = 8'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_ROUND,
    BK_HOLD
  } back_state_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       array_last;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] bin_value;
    logic                    bin_last;
    logic                    length_error;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_req_t;

  typedef struct packed {
    logic [FACTOR_W-1:0] factor;
    logic [POS_W-1:0]    start_position;
    logic [POS_W-1:0]    end_position;
    logic                average_enable;
  } bsd_cfg_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic [FACTOR_W-1:0]     factor;
    logic                    average;
    logic                    bin_last;
    logic                    length_error;
  } bsd_entry_t;

endpackage

`default_nettype wire

// ===== sv/bsd_stream_if.sv =====
// Interface: valid/ready channel carrying one payload per request.
`default_nettype none

interface bsd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== sv/bsd_cfg_regs.sv =====
// Configuration register file with factor clamping.
`default_nettype none

module bsd_cfg_regs
  import bsd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  bsd_stream_if.sink    cfg_i,
  output bsd_cfg_t      cfg_o
);

  logic [FACTOR_W-1:0] factor_q;
  logic [POS_W-1:0]    start_q;
  logic [POS_W-1:0]    end_q;
  logic                avg_q;
  logic                wr;
  cfg_req_t            req;

  assign cfg_i.ready = 1'b1;
  assign wr  = cfg_i.valid;
  assign req = cfg_i.payload;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= FACTOR_W'(1);
      start_q  <= POS_W'(1);
      end_q    <= '0;
      avg_q    <= 1'b0;
    end else if (wr) begin
      case (cfg_reg_e'(req.index))
        CFG_DECIM_FACTOR:   factor_q <= req.data[FACTOR_W-1:0];
        CFG_START_POSITION: start_q  <= req.data[POS_W-1:0];
        CFG_END_POSITION:   end_q    <= req.data[POS_W-1:0];
        CFG_AVERAGE_ENABLE: avg_q    <= req.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.factor = factor_q;
    if (factor_q == '0) begin
      cfg_o.factor = FACTOR_W'(1);
    end else if (factor_q > FACTOR_W'(MAX_FACTOR)) begin
      cfg_o.factor = FACTOR_W'(MAX_FACTOR);
    end
    cfg_o.start_position = start_q;
    cfg_o.end_position   = end_q;
    cfg_o.average_enable = avg_q;
  end

endmodule

`default_nettype wire

// ===== sv/bsd_front.sv =====
// Front end: window selection, bin accumulation and dump request generation.
`default_nettype none

module bsd_front
  import bsd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  bsd_stream_if.sink     in_i,
  input  wire bsd_cfg_t  cfg_i,
  input  wire logic      full_i,
  output logic           push_o,
  output bsd_entry_t     entry_o
);

  localparam logic [POS_W-1:0] POS_MAX = '1;

  logic [POS_W-1:0]    pos_q, pos_d;
  logic [FACTOR_W-1:0] fill_q, fill_d;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic                done_q, done_d;

  in_item_t            item;
  logic                take;
  logic [POS_W-1:0]    pos_new;
  logic [FACTOR_W-1:0] fill_new;
  logic [ACC_W-1:0]    acc_new;
  logic                kept, closing, dump, err_close, err_empty;

  assign item       = in_i.payload;
  assign in_i.ready = !full_i;
  assign take       = in_i.valid && !full_i;

  always_comb begin
    pos_new  = (pos_q != POS_MAX) ? pos_q + POS_W'(1) : POS_MAX;
    kept     = !done_q && (pos_new >= cfg_i.start_position) &&
               ((cfg_i.end_position == '0) || (pos_new <= cfg_i.end_position));
    acc_new  = acc_q + ACC_W'($signed(item.sample[SAMPLE_USE-1:0]));
    fill_new = fill_q + FACTOR_W'(1);
    closing  = kept && (((cfg_i.end_position != '0) && (pos_new == cfg_i.end_position)) ||
                        item.array_last);
    dump      = kept && (fill_new >= cfg_i.factor);
    err_close = closing && !dump;
    err_empty = item.array_last && !done_q && !kept;

    push_o               = take && (dump || err_close || err_empty);
    entry_o.acc          = acc_new;
    entry_o.factor       = cfg_i.factor;
    entry_o.average      = cfg_i.average_enable;
    entry_o.bin_last     = closing || err_empty;
    entry_o.length_error = err_close || err_empty;

    pos_d  = pos_q;
    fill_d = fill_q;
    acc_d  = acc_q;
    done_d = done_q;
    if (take) begin
      pos_d = pos_new;
      if (kept) begin
        if (dump || closing) begin
          fill_d = '0;
          acc_d  = '0;
        end else begin
          fill_d = fill_new;
          acc_d  = acc_new;
        end
        done_d = done_q || closing;
      end
      if (item.array_last) begin
        pos_d  = '0;
        fill_d = '0;
        acc_d  = '0;
        done_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      fill_q <= '0;
      acc_q  <= '0;
      done_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      fill_q <= fill_d;
      acc_q  <= acc_d;
      done_q <= done_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bsd_queue.sv =====
// Small FIFO of dump requests between front and back.
`default_nettype none

module bsd_queue
  import bsd_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire bsd_entry_t entry_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output logic            valid_o,
  output bsd_entry_t      entry_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  bsd_entry_t       slot_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bsd_back.sv =====
// Back end: bit-serial mean division, rounding, saturation and result register.
`default_nettype none

module bsd_back
  import bsd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  input  wire bsd_entry_t entry_i,
  output logic            pop_o,
  bsd_stream_if.source    out_o
);

  localparam logic [63:0]  OUT_LIM  = 64'h0000_8000_0000_0000;
  localparam logic [OUT_W:0] MAG_LIM = (OUT_W + 1)'(OUT_LIM);
  localparam logic [OUT_W:0] POS_LIM = (OUT_W + 1)'(OUT_LIM - 64'd1);

  back_state_e         state_q, state_d;
  logic [NUM_W-1:0]    num_q;
  logic [FACTOR_W:0]   rem_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [FACTOR_W-1:0] d_q;
  logic                neg_q;
  logic                last_q;
  out_item_t           res_q;

  logic [FACTOR_W:0]   rem_sh;
  logic                ge;
  logic [ACC_W-1:0]    mag_in;
  logic [63:0]         q_ext;
  logic                sat, round_up;
  logic [OUT_W:0]      mag_w;
  logic [OUT_W-1:0]    value_r;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (valid_i) begin
          if (entry_i.length_error || !entry_i.average) begin
            state_d = BK_HOLD;
          end else begin
            state_d = BK_DIV;
          end
        end
      end
      BK_DIV:   if (cnt_q == CNT_W'(NUM_W - 1)) state_d = BK_ROUND;
      BK_ROUND: state_d = BK_HOLD;
      BK_HOLD:  if (out_o.ready) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o         = (state_q == BK_IDLE) && valid_i;
    out_o.valid   = (state_q == BK_HOLD);
    out_o.payload = res_q;
  end

  always_comb begin
    rem_sh   = {rem_q[FACTOR_W-1:0], num_q[NUM_W-1]};
    ge       = (rem_sh >= {1'b0, d_q});
    mag_in   = entry_i.acc[ACC_W-1] ? (~entry_i.acc + ACC_W'(1)) : entry_i.acc;
    q_ext    = 64'(num_q);
    sat      = (q_ext >= OUT_LIM);
    round_up = ({rem_q, 1'b0} >= {2'b00, d_q});
    mag_w    = sat ? MAG_LIM : (OUT_W + 1)'(q_ext) + (OUT_W + 1)'(round_up);
    if (neg_q) begin
      value_r = ~mag_w[OUT_W-1:0] + OUT_W'(1);
    end else if (mag_w > POS_LIM) begin
      value_r = POS_LIM[OUT_W-1:0];
    end else begin
      value_r = mag_w[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        if (valid_i) begin
          d_q    <= entry_i.factor;
          last_q <= entry_i.bin_last;
          neg_q  <= entry_i.acc[ACC_W-1];
          num_q  <= {mag_in, {FRAC_BITS{1'b0}}};
          rem_q  <= '0;
          cnt_q  <= '0;
          res_q.bin_last     <= entry_i.bin_last;
          res_q.length_error <= entry_i.length_error;
          if (entry_i.length_error) begin
            res_q.bin_value <= '0;
          end else begin
            res_q.bin_value <= OUT_W'(entry_i.acc);
          end
        end
      end
      BK_DIV: begin
        rem_q <= ge ? rem_sh - {1'b0, d_q} : rem_sh;
        num_q <= {num_q[NUM_W-2:0], ge};
        cnt_q <= cnt_q + CNT_W'(1);
      end
      BK_ROUND: begin
        res_q.bin_value    <= value_r;
        res_q.bin_last     <= last_q;
        res_q.length_error <= 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/block_sum_decimator_top.sv =====
// Top level: boxcar decimator over a selected window of a streamed array.
//
//  channel  modport  payload     request meaning
//  in_i     sink     in_item_t   one array element with last mark
//  out_o    source   out_item_t  one bin sum, mean or length error
//  cfg_i    sink     cfg_req_t   register write (index, data)
//
// Front takes one element per cycle while the dump queue has room.
// A sum or error result goes straight from idle to the hold state in the back; a mean
// first passes through the one-bit-a-cycle divider and the rounding state.
// Reset clears position, open bin, queue and back state; config returns to defaults.
// A stalled output fills the queue, after which the front deasserts ready.
`default_nettype none

module block_sum_decimator_top
  import bsd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  bsd_stream_if.sink   in_i,
  bsd_stream_if.source out_o,
  bsd_stream_if.sink   cfg_i
);

  bsd_cfg_t   cfg;
  logic       push, full, pop, q_valid;
  bsd_entry_t push_entry, head_entry;

  bsd_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  bsd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .cfg_i   (cfg),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  bsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  bsd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .entry_i (head_entry),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire
